// ----- rtl/hgs_pkg.sv -----
// Hungarian assignment solver: shared constants, types and helpers.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package hgs_pkg;

   // Matrix geometry and cost widths
   localparam int MAX_ROWS     = 16;
   localparam int MAX_COLUMNS  = 16;
   localparam int COST_BITS    = 16;
   localparam int STORE_BITS   = COST_BITS + 8;
   localparam int IN_BITS      = 16;
   localparam int ROW_BITS     = $clog2(MAX_ROWS);
   localparam int COL_BITS     = $clog2(MAX_COLUMNS);
   localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int RCNT_BITS    = $clog2(MAX_ROWS + 1);
   localparam int CCNT_BITS    = $clog2(MAX_COLUMNS + 1);
   localparam int PART_BITS    = ((ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS) + 1;
   localparam int ROUND_LIMIT  = 4 * MAX_ROWS * MAX_COLUMNS;
   localparam int ROUND_BITS   = $clog2(ROUND_LIMIT);

   // Result field widths
   localparam int OUT_ROW_BITS = 4;
   localparam int OUT_COL_BITS = 4;

   // Control register port
   localparam int CFG_BITS     = 5;
   localparam int CSR_IDX_BITS = 1;

   typedef logic [STORE_BITS-1:0] cost_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [RCNT_BITS-1:0]  rcnt_type;
   typedef logic [CCNT_BITS-1:0]  ccnt_type;
   typedef logic [PART_BITS-1:0]  part_type;
   typedef logic [ROUND_BITS-1:0] round_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;

   localparam part_type NO_PARTNER = '1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS    = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLUMNS = 1'b1;

   // What to do with a cost word coming back from a memory sweep
   typedef enum logic [2:0] {
      OP_ROW_MIN = 3'd0,
      OP_ROW_SUB = 3'd1,
      OP_COL_MIN = 3'd2,
      OP_COL_SUB = 3'd3,
      OP_UNC_MIN = 3'd4,
      OP_ADJUST  = 3'd5
   } sweep_op_type;

   // Register value to a count: zero reads as one, large values clip
   function automatic int clamp_count(logic [CFG_BITS-1:0] value, int max_count);
      int t;
      t = int'(value);
      if (t == 0) t = 1;
      if (t > max_count) t = max_count;
      return t;
   endfunction

endpackage

// ----- rtl/hgs_if.sv -----
// Valid/ready channels of the assignment solver: cost entries in, row results out.
// Depends on hgs_pkg for the payload widths.
`timescale 1ns / 1ps

interface hgs_req_if;
   import hgs_pkg::*;
   logic               valid;
   logic               ready;
   logic [IN_BITS-1:0] cost_value;
   modport source (output valid, output cost_value, input ready);
   modport sink   (input valid, input cost_value, output ready);
endinterface

interface hgs_rsp_if;
   import hgs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OUT_ROW_BITS-1:0] row_number;
   logic [OUT_COL_BITS-1:0] column_number;
   logic                    is_assigned;
   logic                    last_row;
   modport source (output valid, output row_number, output column_number,
                   output is_assigned, output last_row, input ready);
   modport sink   (input valid, input row_number, input column_number,
                   input is_assigned, input last_row, output ready);
endinterface

// ----- rtl/hgs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hgs_ram #(
   parameter int  WIDTH     = 8,
   parameter int  DEPTH     = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/hungarian_assignment_solver.sv -----
// Operation: R*C cost beats are loaded, then a data-dependent solve: row and column
// reductions, then per round an augmenting search, the cover marking, and the minimum
// search and adjust, for at most 1024 rounds; all sweeps go through the single read port
// of the cost memory. Then R result beats, one per cycle while the receiver is ready.
// Throughput: one cost beat per cycle while loading; no load during solve or results.
// Reset (synchronous, active high): 16x16 matrix, empty load, no results pending.
`timescale 1ns / 1ps

module hungarian_assignment_solver (
   input  logic                              clock,
   input  logic                              reset,
   hgs_req_if.sink                           req_ch,
   hgs_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [hgs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [hgs_pkg::CFG_BITS-1:0]      csr_wdata
);
   import hgs_pkg::*;

   typedef enum logic [28:0] {
      ST_LOAD    = 29'b1 << 0,
      ST_RR_INIT = 29'b1 << 1,
      ST_RR_MIN  = 29'b1 << 2,
      ST_RR_SUBI = 29'b1 << 3,
      ST_RR_SUB  = 29'b1 << 4,
      ST_RR_NEXT = 29'b1 << 5,
      ST_CR_INIT = 29'b1 << 6,
      ST_CR_MIN  = 29'b1 << 7,
      ST_CR_SUBI = 29'b1 << 8,
      ST_CR_SUB  = 29'b1 << 9,
      ST_CR_NEXT = 29'b1 << 10,
      ST_M_START = 29'b1 << 11,
      ST_M_ROW   = 29'b1 << 12,
      ST_M_RD    = 29'b1 << 13,
      ST_M_CHK   = 29'b1 << 14,
      ST_M_UNW   = 29'b1 << 15,
      ST_M_NEXT  = 29'b1 << 16,
      ST_K_INIT  = 29'b1 << 17,
      ST_K_SEED  = 29'b1 << 18,
      ST_K_POP   = 29'b1 << 19,
      ST_K_RD    = 29'b1 << 20,
      ST_K_CHK   = 29'b1 << 21,
      ST_U_START = 29'b1 << 22,
      ST_U_ISS   = 29'b1 << 23,
      ST_U_DEC   = 29'b1 << 24,
      ST_A_ISS   = 29'b1 << 25,
      ST_A_END   = 29'b1 << 26,
      ST_DRAIN   = 29'b1 << 27,
      ST_EMIT    = 29'b1 << 28
   } state_type;

   // Control registers
   state_type state_ff, state_in, ret_ff, ret_in;
   rcnt_type  rows_ff, rows_in;
   ccnt_type  cols_ff, cols_in;
   row_type   lr_ff, lr_in;
   col_type   lc_ff, lc_in;
   row_type   a_ff, a_in;
   col_type   b_ff, b_in;
   logic      rd_vld_ff, rd_vld_in;
   logic      found_ff, found_in;
   part_type  rp_ff [MAX_ROWS];
   part_type  rp_in [MAX_ROWS];
   part_type  cp_ff [MAX_COLUMNS];
   part_type  cp_in [MAX_COLUMNS];
   logic [MAX_ROWS-1:0]    seen_ff, seen_in, rm_ff, rm_in;
   logic [MAX_COLUMNS-1:0] cm_ff, cm_in;
   rcnt_type  head_ff, head_in, tail_ff, tail_in;
   rcnt_type  sp_ff, sp_in;
   rcnt_type  match_ff, match_in;
   round_type round_ff, round_in;
   rcnt_type  e_ff, e_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Payload registers
   cost_type     min_ff, min_in;
   sweep_op_type rd_op_ff, rd_op_in;
   row_type      rd_row_ff, rd_row_in;
   col_type      rd_col_ff, rd_col_in;
   row_type      fifo_ff [MAX_ROWS];
   row_type      fifo_in [MAX_ROWS];
   row_type      stk_row_ff [MAX_ROWS];
   row_type      stk_row_in [MAX_ROWS];
   ccnt_type     stk_col_ff [MAX_ROWS];
   ccnt_type     stk_col_in [MAX_ROWS];
   row_type      top_row_ff, top_row_in;
   ccnt_type     top_col_ff, top_col_in;
   row_type      cur_ff, cur_in;
   ccnt_type     k_col_ff, k_col_in;
   logic [OUT_ROW_BITS-1:0] rsp_row_ff, rsp_row_in;
   logic [OUT_COL_BITS-1:0] rsp_col_ff, rsp_col_in;
   logic         rsp_asg_ff, rsp_asg_in, rsp_last_ff, rsp_last_in;

   // Cost memory ports
   logic     mem_we;
   addr_type mem_waddr, mem_raddr;
   cost_type mem_wdata, mem_rdata;

   hgs_ram #(.WIDTH(STORE_BITS), .DEPTH(STORE_DEPTH)) u_cost_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   logic req_fire;
   logic a_last, b_last, lr_last, lc_last;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_LOAD);
   assign a_last  = (rcnt_type'(a_ff)  == rows_ff - rcnt_type'(1));
   assign b_last  = (ccnt_type'(b_ff)  == cols_ff - ccnt_type'(1));
   assign lr_last = (rcnt_type'(lr_ff) == rows_ff - rcnt_type'(1));
   assign lc_last = (ccnt_type'(lc_ff) == cols_ff - ccnt_type'(1));

   // Main sequencer, sweep data path and handshakes
   always_comb begin
      logic [STORE_BITS:0] sum;
      part_type owner;
      row_type  owner_row;
      col_type  owner_idx;
      part_type part;
      logic     iss;
      sweep_op_type iss_op;
      row_type  sel_row;
      col_type  sel_col;

      state_in = state_ff;     ret_in = ret_ff;
      rows_in = rows_ff;       cols_in = cols_ff;
      lr_in = lr_ff;           lc_in = lc_ff;
      a_in = a_ff;             b_in = b_ff;
      found_in = found_ff;     min_in = min_ff;
      rp_in = rp_ff;           cp_in = cp_ff;
      seen_in = seen_ff;       rm_in = rm_ff;          cm_in = cm_ff;
      head_in = head_ff;       tail_in = tail_ff;      fifo_in = fifo_ff;
      sp_in = sp_ff;           stk_row_in = stk_row_ff; stk_col_in = stk_col_ff;
      top_row_in = top_row_ff; top_col_in = top_col_ff;
      match_in = match_ff;     round_in = round_ff;
      cur_in = cur_ff;         k_col_in = k_col_ff;
      e_in = e_ff;             rsp_valid_in = rsp_valid_ff;
      rsp_row_in = rsp_row_ff; rsp_col_in = rsp_col_ff;
      rsp_asg_in = rsp_asg_ff; rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;           mem_waddr = {rd_row_ff, rd_col_ff};
      mem_wdata = mem_rdata;
      iss = 1'b0;              iss_op = OP_ROW_MIN;
      sel_row = a_ff;          sel_col = b_ff;
      sum = {1'b0, mem_rdata} + {1'b0, min_ff};
      owner_idx = (state_ff == ST_K_CHK) ? k_col_ff[COL_BITS-1:0]
                                         : top_col_ff[COL_BITS-1:0];
      owner = cp_ff[owner_idx];
      owner_row = owner[ROW_BITS-1:0];
      part = rp_ff[e_ff[ROW_BITS-1:0]];

      // Sweep data returning from the memory in the cycle after its read
      if (rd_vld_ff) begin
         unique case (rd_op_ff)
            OP_ROW_MIN, OP_COL_MIN: begin
               if (!found_ff || mem_rdata < min_ff) begin
                  min_in = mem_rdata;
                  found_in = 1'b1;
               end
            end
            OP_ROW_SUB, OP_COL_SUB: begin
               mem_we = 1'b1;
               mem_wdata = mem_rdata - min_ff;
            end
            OP_UNC_MIN: begin
               if (rm_ff[rd_row_ff] && !cm_ff[rd_col_ff]
                   && (!found_ff || mem_rdata < min_ff)) begin
                  min_in = mem_rdata;
                  found_in = 1'b1;
               end
            end
            OP_ADJUST: begin
               if (rm_ff[rd_row_ff] && !cm_ff[rd_col_ff]) begin
                  mem_we = 1'b1;
                  mem_wdata = mem_rdata - min_ff;
               end else if (!rm_ff[rd_row_ff] && cm_ff[rd_col_ff]) begin
                  mem_we = 1'b1;
                  mem_wdata = sum[STORE_BITS] ? '1 : sum[STORE_BITS-1:0];
               end
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               mem_we = 1'b1;
               mem_waddr = {lr_ff, lc_ff};
               mem_wdata = cost_type'(req_ch.cost_value[COST_BITS-1:0]);
               if (lc_last) begin
                  lc_in = '0;
                  if (lr_last) begin
                     lr_in = '0;
                     a_in = '0;
                     state_in = ST_RR_INIT;
                  end else begin
                     lr_in = lr_ff + row_type'(1);
                  end
               end else begin
                  lc_in = lc_ff + col_type'(1);
               end
            end
         end
         // Row reduction: minimum pass then subtract pass per row
         ST_RR_INIT: begin
            found_in = 1'b0;
            b_in = '0;
            state_in = ST_RR_MIN;
         end
         ST_RR_MIN: begin
            iss = 1'b1;
            iss_op = OP_ROW_MIN;
            if (b_last) begin
               ret_in = ST_RR_SUBI;
               state_in = ST_DRAIN;
            end else begin
               b_in = b_ff + col_type'(1);
            end
         end
         ST_RR_SUBI: begin
            b_in = '0;
            state_in = ST_RR_SUB;
         end
         ST_RR_SUB: begin
            iss = 1'b1;
            iss_op = OP_ROW_SUB;
            if (b_last) begin
               ret_in = ST_RR_NEXT;
               state_in = ST_DRAIN;
            end else begin
               b_in = b_ff + col_type'(1);
            end
         end
         ST_RR_NEXT: begin
            if (a_last) begin
               a_in = '0;
               b_in = '0;
               state_in = ST_CR_INIT;
            end else begin
               a_in = a_ff + row_type'(1);
               state_in = ST_RR_INIT;
            end
         end
         // Column reduction
         ST_CR_INIT: begin
            found_in = 1'b0;
            a_in = '0;
            state_in = ST_CR_MIN;
         end
         ST_CR_MIN: begin
            iss = 1'b1;
            iss_op = OP_COL_MIN;
            if (a_last) begin
               ret_in = ST_CR_SUBI;
               state_in = ST_DRAIN;
            end else begin
               a_in = a_ff + row_type'(1);
            end
         end
         ST_CR_SUBI: begin
            a_in = '0;
            state_in = ST_CR_SUB;
         end
         ST_CR_SUB: begin
            iss = 1'b1;
            iss_op = OP_COL_SUB;
            if (a_last) begin
               ret_in = ST_CR_NEXT;
               state_in = ST_DRAIN;
            end else begin
               a_in = a_ff + row_type'(1);
            end
         end
         ST_CR_NEXT: begin
            if (b_last) begin
               round_in = '0;
               state_in = ST_M_START;
            end else begin
               b_in = b_ff + col_type'(1);
               state_in = ST_CR_INIT;
            end
         end
         // Maximum matching: depth-first augmenting search with an explicit stack
         ST_M_START: begin
            for (int i = 0; i < MAX_ROWS; i++) rp_in[i] = NO_PARTNER;
            for (int i = 0; i < MAX_COLUMNS; i++) cp_in[i] = NO_PARTNER;
            match_in = '0;
            a_in = '0;
            state_in = ST_M_ROW;
         end
         ST_M_ROW: begin
            seen_in = '0;
            seen_in[a_ff] = 1'b1;
            top_row_in = a_ff;
            top_col_in = '0;
            sp_in = '0;
            state_in = ST_M_RD;
         end
         ST_M_RD: begin
            if (top_col_ff < cols_ff) begin
               sel_row = top_row_ff;
               sel_col = top_col_ff[COL_BITS-1:0];
               state_in = ST_M_CHK;
            end else if (sp_ff == '0) begin
               state_in = ST_M_NEXT;
            end else begin
               // dead end: back to the parent, which moves to its next column
               top_row_in = stk_row_ff[sp_ff[ROW_BITS-1:0] - row_type'(1)];
               top_col_in = stk_col_ff[sp_ff[ROW_BITS-1:0] - row_type'(1)]
                            + ccnt_type'(1);
               sp_in = sp_ff - rcnt_type'(1);
            end
         end
         ST_M_CHK: begin
            state_in = ST_M_RD;
            top_col_in = top_col_ff + ccnt_type'(1);
            if (mem_rdata == '0) begin
               if (owner == NO_PARTNER) begin
                  top_col_in = top_col_ff;
                  state_in = ST_M_UNW;
               end else if (!seen_ff[owner_row]) begin
                  seen_in[owner_row] = 1'b1;
                  stk_row_in[sp_ff[ROW_BITS-1:0]] = top_row_ff;
                  stk_col_in[sp_ff[ROW_BITS-1:0]] = top_col_ff;
                  sp_in = sp_ff + rcnt_type'(1);
                  top_row_in = owner_row;
                  top_col_in = '0;
               end
            end
         end
         ST_M_UNW: begin
            // flip the path, deepest frame first
            rp_in[top_row_ff] = part_type'(top_col_ff);
            cp_in[top_col_ff[COL_BITS-1:0]] = part_type'(top_row_ff);
            if (sp_ff == '0) begin
               match_in = match_ff + rcnt_type'(1);
               state_in = ST_M_NEXT;
            end else begin
               top_row_in = stk_row_ff[sp_ff[ROW_BITS-1:0] - row_type'(1)];
               top_col_in = stk_col_ff[sp_ff[ROW_BITS-1:0] - row_type'(1)];
               sp_in = sp_ff - rcnt_type'(1);
            end
         end
         ST_M_NEXT: begin
            if (a_last) begin
               if (match_ff == rows_ff) begin
                  e_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_K_INIT;
               end
            end else begin
               a_in = a_ff + row_type'(1);
               state_in = ST_M_ROW;
            end
         end
         // Cover marking: breadth-first from unmatched rows
         ST_K_INIT: begin
            rm_in = '0;
            cm_in = '0;
            head_in = '0;
            tail_in = '0;
            a_in = '0;
            state_in = ST_K_SEED;
         end
         ST_K_SEED: begin
            if (rp_ff[a_ff] == NO_PARTNER) begin
               rm_in[a_ff] = 1'b1;
               fifo_in[tail_ff[ROW_BITS-1:0]] = a_ff;
               tail_in = tail_ff + rcnt_type'(1);
            end
            if (a_last) begin
               state_in = ST_K_POP;
            end else begin
               a_in = a_ff + row_type'(1);
            end
         end
         ST_K_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_U_START;
            end else begin
               cur_in = fifo_ff[head_ff[ROW_BITS-1:0]];
               head_in = head_ff + rcnt_type'(1);
               k_col_in = '0;
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            if (k_col_ff < cols_ff) begin
               sel_row = cur_ff;
               sel_col = k_col_ff[COL_BITS-1:0];
               state_in = ST_K_CHK;
            end else begin
               state_in = ST_K_POP;
            end
         end
         ST_K_CHK: begin
            if (mem_rdata == '0 && !cm_ff[owner_idx]) begin
               cm_in[owner_idx] = 1'b1;
               if (owner != NO_PARTNER && !rm_ff[owner_row]) begin
                  rm_in[owner_row] = 1'b1;
                  fifo_in[tail_ff[ROW_BITS-1:0]] = owner_row;
                  tail_in = tail_ff + rcnt_type'(1);
               end
            end
            k_col_in = k_col_ff + ccnt_type'(1);
            state_in = ST_K_RD;
         end
         // Least uncovered value over the whole matrix, then the adjust sweep and the round count
         ST_U_START: begin
            found_in = 1'b0;
            a_in = '0;
            b_in = '0;
            state_in = ST_U_ISS;
         end
         ST_U_ISS, ST_A_ISS: begin
            iss = 1'b1;
            iss_op = (state_ff == ST_U_ISS) ? OP_UNC_MIN : OP_ADJUST;
            if (b_last) begin
               b_in = '0;
               if (a_last) begin
                  ret_in = (state_ff == ST_U_ISS) ? ST_U_DEC : ST_A_END;
                  state_in = ST_DRAIN;
               end else begin
                  a_in = a_ff + row_type'(1);
               end
            end else begin
               b_in = b_ff + col_type'(1);
            end
         end
         ST_U_DEC: begin
            if (!found_ff) begin
               e_in = '0;
               state_in = ST_EMIT;
            end else begin
               a_in = '0;
               b_in = '0;
               state_in = ST_A_ISS;
            end
         end
         ST_A_END: begin
            if (round_ff == round_type'(ROUND_LIMIT - 1)) begin
               e_in = '0;
               state_in = ST_EMIT;
            end else begin
               round_in = round_ff + round_type'(1);
               state_in = ST_M_START;
            end
         end
         // Lets the last read-modify-write of a sweep land before the next read
         ST_DRAIN: begin
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (e_ff < rows_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in = OUT_ROW_BITS'(e_ff[ROW_BITS-1:0]);
                  rsp_asg_in = (part != NO_PARTNER);
                  rsp_col_in = (part != NO_PARTNER) ? OUT_COL_BITS'(part[COL_BITS-1:0])
                                                    : '0;
                  rsp_last_in = (e_ff == rows_ff - rcnt_type'(1));
                  e_in = e_ff + rcnt_type'(1);
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // Control register writes restart the load
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS:    rows_in = rcnt_type'(clamp_count(csr_wdata, MAX_ROWS));
            CSR_COLUMNS: cols_in = ccnt_type'(clamp_count(csr_wdata, MAX_COLUMNS));
            default: ;
         endcase
         lr_in = '0;
         lc_in = '0;
      end

      mem_raddr = {sel_row, sel_col};
      rd_vld_in = iss;
      rd_op_in = iss_op;
      rd_row_in = sel_row;
      rd_col_in = sel_col;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ret_ff <= ST_LOAD;
         rows_ff <= rcnt_type'(MAX_ROWS);
         cols_ff <= ccnt_type'(MAX_COLUMNS);
         lr_ff <= '0;
         lc_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
         rd_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) rp_ff[i] <= NO_PARTNER;
         for (int i = 0; i < MAX_COLUMNS; i++) cp_ff[i] <= NO_PARTNER;
         seen_ff <= '0;
         rm_ff <= '0;
         cm_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         sp_ff <= '0;
         match_ff <= '0;
         round_ff <= '0;
         e_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         lr_ff <= lr_in;
         lc_ff <= lc_in;
         a_ff <= a_in;
         b_ff <= b_in;
         rd_vld_ff <= rd_vld_in;
         found_ff <= found_in;
         rp_ff <= rp_in;
         cp_ff <= cp_in;
         seen_ff <= seen_in;
         rm_ff <= rm_in;
         cm_ff <= cm_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         sp_ff <= sp_in;
         match_ff <= match_in;
         round_ff <= round_in;
         e_ff <= e_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      min_ff <= min_in;
      rd_op_ff <= rd_op_in;
      rd_row_ff <= rd_row_in;
      rd_col_ff <= rd_col_in;
      fifo_ff <= fifo_in;
      stk_row_ff <= stk_row_in;
      stk_col_ff <= stk_col_in;
      top_row_ff <= top_row_in;
      top_col_ff <= top_col_in;
      cur_ff <= cur_in;
      k_col_ff <= k_col_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_asg_ff <= rsp_asg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.row_number = rsp_row_ff;
   assign rsp_ch.column_number = rsp_col_ff;
   assign rsp_ch.is_assigned = rsp_asg_ff;
   assign rsp_ch.last_row = rsp_last_ff;

   // Checks
   a_no_load_during_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> !req_fire)
      else $error("cost beat accepted while sweep data pending");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_M_RD) |-> (sp_ff < rows_ff))
      else $error("search stack deeper than the row count");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_POP) |-> (head_ff <= tail_ff && tail_ff <= rows_ff))
      else $error("row queue pointers out of range");

   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("result beat outside the emit phase");

endmodule
